// ===== sv/mls_pkg.sv =====
// Shared types and constants for the linear sieve block.
// Holds the command and result words, the function codes and the Mobius codes.
// No dependencies.
package mls_pkg;

    localparam int FIELD_W = 17;   // width of limit and index
    localparam int COUNT_W = 13;   // width of the reported prime count

    typedef logic signed [1:0] mu_t;

    localparam mu_t MU_ZERO = 2'sd0;
    localparam mu_t MU_ONE  = 2'sd1;
    localparam mu_t MU_NEG  = -2'sd1;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] limit;
        logic [FIELD_W-1:0] index;
    } in_word_t;

    typedef struct packed {
        mu_t                mobius;
        logic               is_prime;
        logic [COUNT_W-1:0] prime_count;
        logic               out_of_range;
    } out_word_t;

endpackage

// ===== sv/mls_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
// Used for the sieve table and the prime list. No package dependencies.
module mls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mobius_linear_sieve.sv =====
// Top level of the linear sieve: command decode, sieve sequencer, lookups.
// Depends on mls_pkg (word types, codes) and mls_ram (table and prime list).
//
// Usage: present a word on cmd with start high; it is taken when busy is low.
// Exactly one result word follows per command, shown on result for a single
// cycle with done high; the receiver cannot stall it, so capture it then.
// A query (func 1) is one table read (S_Q_RD), then the result is
// formatted and registered (S_Q_OUT). A build (func 0, limit n,
// saturated to MAX_N) clears table entries 1..n (S_CLR), then for each
// i in 2..n reads and classifies i (S_I_RD, S_I_CHK) and, for each prime
// tried against i, reads the prime list, multiplies, then compares and
// strikes (S_K_RD, S_K_MUL, S_K_CHK), then reports (S_FIN). About 1.5n
// primes are tried in all. The build is paced by the single write port
// of the sieve table and the one shared multiplier. Entries above the
// built limit are never used, so reset needs no clearing pass: before
// any build every query reports out of range.
module mobius_linear_sieve #(
    parameter int MAX_N = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mls_pkg::in_word_t  cmd,
    output logic               done,
    output mls_pkg::out_word_t result
);
    import mls_pkg::*;

    localparam int AW        = $clog2(MAX_N + 1);
    localparam int PRIME_CAP = MAX_N / 2 + 2;
    localparam int KW        = $clog2(PRIME_CAP);
    localparam int PW        = $clog2(PRIME_CAP + 1);
    localparam int TW        = KW + 3;
    localparam int CW        = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int MW        = 2 * AW;
    localparam int TB_COMP   = KW + 2;   // table word: composite flag
    localparam int TB_MU_LO  = KW;       // table word: Mobius at [KW+1:KW]

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_Q_RD  = 10'b0000000010,
        S_Q_OUT = 10'b0000000100,
        S_CLR   = 10'b0000001000,
        S_I_RD  = 10'b0000010000,
        S_I_CHK = 10'b0000100000,
        S_K_RD  = 10'b0001000000,
        S_K_MUL = 10'b0010000000,
        S_K_CHK = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        built_reg, built_next;
    logic [PW-1:0]        pf_reg, pf_next;
    logic                 done_reg, done_next;
    out_word_t            result_reg, result_next;
    logic [AW-1:0]        n_reg, n_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        spf_reg, spf_next;
    mu_t                  mu_reg, mu_next;
    logic [MW-1:0]        prod_reg, prod_next;
    logic [FIELD_W-1:0]   idx_reg, idx_next;
    logic                 oor_reg, oor_next;

    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [TW-1:0]        tbl_wdata;
    logic [AW-1:0]        tbl_raddr;
    logic [TW-1:0]        tbl_rdata;
    logic                 pl_we;
    logic [KW-1:0]        pl_waddr;
    logic [AW-1:0]        pl_wdata;
    logic [KW-1:0]        pl_raddr;
    logic [AW-1:0]        pl_rdata;

    logic                 accept;
    logic [CW-1:0]        lim_ext;
    logic [AW-1:0]        lim_sat;
    logic                 last_k;
    mu_t                  mu_strike;

    // table word: {composite, mobius[1:0], index of smallest prime factor}
    mls_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_N + 1)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // primes in increasing order
    mls_ram #(
        .WIDTH (AW),
        .DEPTH (PRIME_CAP)
    ) u_plist (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign lim_ext = CW'(cmd.limit);
    assign lim_sat = (lim_ext > CW'(MAX_N)) ? AW'(MAX_N) : AW'(lim_ext);

    // i % p == 0 exactly when p is the smallest prime factor of i
    assign last_k    = (k_reg == spf_reg);
    assign mu_strike = last_k ? MU_ZERO : mu_t'(-mu_reg);

    always_comb
    begin
        state_next  = state_reg;
        built_next  = built_reg;
        pf_next     = pf_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        spf_next    = spf_reg;
        mu_next     = mu_reg;
        prod_next   = prod_reg;
        idx_next    = idx_reg;
        oor_next    = oor_reg;

        tbl_we    = 1'b0;
        tbl_waddr = i_reg;
        tbl_wdata = '0;
        tbl_raddr = i_reg;
        pl_we     = 1'b0;
        pl_waddr  = KW'(pf_reg);
        pl_wdata  = i_reg;
        pl_raddr  = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_QUERY)
                    begin
                        idx_next   = cmd.index;
                        oor_next   = (cmd.index == '0) ||
                                     (CW'(cmd.index) > CW'(built_reg));
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        n_next     = lim_sat;
                        built_next = lim_sat;
                        pf_next    = '0;
                        i_next     = AW'(1);
                        state_next = (lim_sat == '0) ? S_FIN : S_CLR;
                    end
                end
            end

            S_Q_RD:
            begin
                tbl_raddr  = AW'(idx_reg);
                state_next = S_Q_OUT;
            end

            S_Q_OUT:
            begin
                done_next               = 1'b1;
                result_next.prime_count = COUNT_W'(pf_reg);
                result_next.out_of_range = oor_reg;
                if (oor_reg)
                begin
                    result_next.mobius   = MU_ZERO;
                    result_next.is_prime = 1'b0;
                end
                else
                begin
                    result_next.mobius   = mu_t'(tbl_rdata[TB_MU_LO +: 2]);
                    result_next.is_prime = !tbl_rdata[TB_COMP];
                end
                state_next = S_IDLE;
            end

            S_CLR:
            begin
                // one is marked non-prime with Mobius one; others cleared
                tbl_we    = 1'b1;
                tbl_waddr = i_reg;
                tbl_wdata = (i_reg == AW'(1)) ? {1'b1, MU_ONE, {KW{1'b0}}} : '0;
                if (i_reg == n_reg)
                begin
                    i_next     = AW'(2);
                    state_next = (n_reg < AW'(2)) ? S_FIN : S_I_RD;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end

            S_I_RD:
            begin
                tbl_raddr  = i_reg;
                state_next = S_I_CHK;
            end

            S_I_CHK:
            begin
                k_next = '0;
                if (!tbl_rdata[TB_COMP])
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = i_reg;
                    tbl_wdata = {1'b0, MU_NEG, KW'(pf_reg)};
                    pl_we     = 1'b1;
                    pl_waddr  = KW'(pf_reg);
                    pl_wdata  = i_reg;
                    pf_next   = pf_reg + PW'(1);
                    mu_next   = MU_NEG;
                    spf_next  = KW'(pf_reg);
                end
                else
                begin
                    mu_next  = mu_t'(tbl_rdata[TB_MU_LO +: 2]);
                    spf_next = tbl_rdata[KW-1:0];
                end
                state_next = S_K_RD;
            end

            S_K_RD:
            begin
                pl_raddr   = k_reg;
                state_next = S_K_MUL;
            end

            S_K_MUL:
            begin
                prod_next  = MW'(i_reg) * MW'(pl_rdata);
                state_next = S_K_CHK;
            end

            S_K_CHK:
            begin
                if (prod_reg > MW'(n_reg) || last_k)
                begin
                    if (prod_reg <= MW'(n_reg))
                    begin
                        tbl_we    = 1'b1;
                        tbl_waddr = prod_reg[AW-1:0];
                        tbl_wdata = {1'b1, mu_strike, k_reg};
                    end
                    if (i_reg == n_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = S_I_RD;
                    end
                end
                else
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = prod_reg[AW-1:0];
                    tbl_wdata  = {1'b1, mu_strike, k_reg};
                    k_next     = k_reg + KW'(1);
                    state_next = S_K_RD;
                end
            end

            S_FIN:
            begin
                done_next                = 1'b1;
                result_next.mobius       = MU_ZERO;
                result_next.is_prime     = 1'b0;
                result_next.prime_count  = COUNT_W'(pf_reg);
                result_next.out_of_range = 1'b0;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            built_reg <= '0;
            pf_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            pf_reg    <= pf_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        spf_reg    <= spf_next;
        mu_reg     <= mu_next;
        prod_reg   <= prod_next;
        idx_reg    <= idx_next;
        oor_reg    <= oor_next;
    end

    // one result word per command; the done strobe is never held high
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    // an accepted command always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command accepted but block not busy");

    // the sieve never writes past its current limit
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (tbl_waddr <= n_reg))
        else $error("sieve table write beyond built limit");

    // prime count stays within the prime list
    a_pf_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (pf_reg <= PW'(PRIME_CAP)))
        else $error("prime count overflows prime list");

    // the inner loop never passes the smallest prime factor of i
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_K_CHK) |-> (k_reg <= spf_reg))
        else $error("prime index passed smallest factor");

endmodule

// ===== tb/tb_mobius_linear_sieve.sv =====
// Testbench for mobius_linear_sieve: build and query words checked against a software sieve.
// Depends on mls_pkg (word types, function and Mobius codes) and the block itself.
// A short directed run covers the edge cases, then random build/query sequences follow.

// Software copy of the sieve tables plus the queue of result words still due.
class mobius_tracker #(int TABLE_MAX = 65536);

    localparam int PRIME_SLOTS = TABLE_MAX / 2 + 2;

    mls_pkg::mu_t         mu_tbl[0:TABLE_MAX];
    bit                   comp_map[0:TABLE_MAX];
    int unsigned          prime_tbl[0:PRIME_SLOTS-1];
    int unsigned          primes_found;
    int unsigned          built_limit;
    mls_pkg::out_word_t   pending[$];
    int                   errors;

    function new();
        foreach (mu_tbl[i])
        begin
            mu_tbl[i]   = mls_pkg::MU_ZERO;
            comp_map[i] = 1'b0;
        end
        primes_found = 0;
        built_limit  = 0;
        errors       = 0;
    endfunction

    // Euler sieve: each composite is struck once, by its smallest prime factor.
    function void run_sieve(int unsigned n);
        int unsigned i;
        int unsigned k;
        int unsigned p;
        int unsigned m;
        // everything above the old limit is still zero, so clear up to it only
        for (i = 0; i <= built_limit; i++)
        begin
            mu_tbl[i]   = mls_pkg::MU_ZERO;
            comp_map[i] = 1'b0;
        end
        primes_found = 0;
        if (n > TABLE_MAX)
            n = TABLE_MAX;
        built_limit = n;
        if (n == 0)
            return;
        comp_map[1] = 1'b1;
        mu_tbl[1]   = mls_pkg::MU_ONE;
        for (i = 2; i <= n; i++)
        begin
            if (!comp_map[i] && primes_found < PRIME_SLOTS)
            begin
                prime_tbl[primes_found] = i;
                primes_found++;
                mu_tbl[i] = mls_pkg::MU_NEG;
            end
            for (k = 0; k < primes_found; k++)
            begin
                p = prime_tbl[k];
                if (i > n / p)
                    break;
                m = i * p;
                comp_map[m] = 1'b1;
                if (i % p == 0)
                begin
                    mu_tbl[m] = mls_pkg::MU_ZERO;
                    break;
                end
                mu_tbl[m] = -mu_tbl[i];
            end
        end
    endfunction

    // Called for every accepted command word.
    function void note_command(mls_pkg::in_word_t w);
        mls_pkg::out_word_t want;
        want = '0;
        if (w.func == mls_pkg::FUNC_BUILD)
            run_sieve(w.limit);
        else if (w.index == 0 || w.index > built_limit)
            want.out_of_range = 1'b1;
        else
        begin
            want.mobius   = mu_tbl[w.index];
            want.is_prime = (w.index >= 2) && !comp_map[w.index];
        end
        want.prime_count = primes_found[mls_pkg::COUNT_W-1:0];
        pending.insert(pending.size(), want);
    endfunction

    // Called for every result word seen with done high.
    function void check_result(mls_pkg::out_word_t got);
        mls_pkg::out_word_t want;
        if (pending.size() == 0)
        begin
            $error("result word with no command pending");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.mobius !== want.mobius)
        begin
            $error("mobius expected %0d actual %0d", want.mobius, got.mobius);
            errors++;
        end
        if (got.is_prime !== want.is_prime)
        begin
            $error("is_prime expected %0d actual %0d", want.is_prime, got.is_prime);
            errors++;
        end
        if (got.prime_count !== want.prime_count)
        begin
            $error("prime_count expected %0d actual %0d", want.prime_count, got.prime_count);
            errors++;
        end
        if (got.out_of_range !== want.out_of_range)
        begin
            $error("out_of_range expected %0d actual %0d", want.out_of_range,
                   got.out_of_range);
            errors++;
        end
    endfunction

endclass

module tb_mobius_linear_sieve;

    import mls_pkg::*;

    localparam int SIEVE_MAX   = 65536;
    localparam int TOTAL_WORDS = 1150;
    localparam int HALF_PERIOD = 4;
    localparam int FIELD_MASK  = (1 << FIELD_W) - 1;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   cmd;
    logic       done;
    out_word_t  result;

    mobius_tracker #(SIEVE_MAX) tracker;

    int burst_left;
    int words_sent;

    mobius_linear_sieve #(
        .MAX_N (SIEVE_MAX)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // hard stop; the slowest legal run is well inside this
    initial
    begin
        #64_000_000;
        $display("Mismatches found");
        $finish;
    end

    // results cannot be held off: take every strobed word at the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            tracker.check_result(result);
    end

    // Send one command word. The sender runs in bursts; a gap of idle cycles
    // with start low may come before the word. Start stays high after the
    // accepting edge, so back-to-back words never lower and raise it in one step.
    task automatic issue_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_command(w);
        burst_left--;
        words_sent++;
    endtask

    // the unused field of each word carries random junk
    task automatic build_word(input int unsigned lim);
        in_word_t w;
        w.func  = FUNC_BUILD;
        w.limit = lim[FIELD_W-1:0];
        w.index = FIELD_W'($urandom & FIELD_MASK);
        issue_word(w);
    endtask

    task automatic query_word(input int unsigned idx);
        in_word_t w;
        w.func  = FUNC_QUERY;
        w.limit = FIELD_W'($urandom & FIELD_MASK);
        w.index = idx[FIELD_W-1:0];
        issue_word(w);
    endtask

    // mostly small tables so builds stay short; a few tiny and mid-size ones
    function automatic int unsigned pick_limit();
        int unsigned sel;
        sel = $urandom_range(0, 29);
        if (sel < 3)
            return $urandom_range(0, 3);
        else if (sel < 5)
            return $urandom_range(301, 1500);
        else
            return $urandom_range(1, 300);
    endfunction

    // mostly inside the table or just past its end, some tiny, some anywhere
    function automatic int unsigned pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return $urandom_range(0, tracker.built_limit + 3);
        else if (sel < 9)
            return $urandom_range(0, 3);
        else
            return $urandom & FIELD_MASK;
    endfunction

    initial
    begin
        int n_q;
        tracker    = new();
        burst_left = 0;
        words_sent = 0;
        start      = 1'b0;
        cmd        = '0;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // queries before any build are out of range
        query_word(0);
        query_word(5);
        // empty build: everything out of range afterwards
        build_word(0);
        query_word(1);
        // one-entry table: index one is Mobius 1 and not prime
        build_word(1);
        query_word(1);
        query_word(2);
        build_word(2);
        query_word(2);
        build_word(30);
        query_word(0);
        query_word(4);
        query_word(6);
        query_word(29);
        query_word(30);
        query_word(31);
        query_word(FIELD_MASK);
        // limit past the table size saturates
        build_word(FIELD_MASK);
        query_word(65536);
        query_word(65535);
        query_word(65521);
        query_word(65537);
        build_word(SIEVE_MAX);
        query_word(1);

        // random lookups on the full table
        repeat (150) query_word(pick_index());

        // build then a run of lookups on it
        while (words_sent < TOTAL_WORDS)
        begin
            build_word(pick_limit());
            n_q = $urandom_range(3, 30);
            repeat (n_q) query_word(pick_index());
        end

        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== mobius_linear_sieve.f =====
sv/mls_pkg.sv
sv/mls_ram.sv
sv/mobius_linear_sieve.sv
tb/tb_mobius_linear_sieve.sv
